[design/utf8_to_utf16_transcoder_top_macros.svh]
// Assertion macros shared by the transcoder RTL.
`ifndef UTF8_TO_UTF16_TRANSCODER_TOP_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_TOP_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define U8U16_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define U8U16_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define U8U16_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/u8u16_pkg.sv]
// Types and constants shared by the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps
`default_nettype none
package u8u16_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned VALUE_W = 31;
    localparam int unsigned PEND_W  = 3;

    localparam logic [VALUE_W-1:0] C_SUPP_BASE = 31'h0001_0000;
    localparam logic [UNIT_W-1:0]  C_HI_SURR   = 16'hD800;
    localparam logic [UNIT_W-1:0]  C_LO_SURR   = 16'hDC00;

    // one output unit as it leaves the block
    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              run_last;
        logic              stream_end;
    } t_unit;

    // result of one decoded byte: zero, one or two units
    typedef struct packed {
        logic [1:0] cnt;
        t_unit      u0;
        t_unit      u1;
    } t_dec_res;

endpackage
`default_nettype wire

[design/u8u16_decode.sv]
// Byte decoder: sequence state and code unit generation for one byte.
`timescale 1ns / 1ps
`default_nettype none
module u8u16_decode (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic [u8u16_pkg::BYTE_W-1:0]   i_byte,
    input  wire logic                           i_last,
    output u8u16_pkg::t_dec_res                 o_res
);
    import u8u16_pkg::*;

    logic [PEND_W-1:0]  r_pend;
    logic [PEND_W-1:0]  n_pend;
    logic [VALUE_W-1:0] r_val;
    logic [VALUE_W-1:0] n_val;

    logic               emit;
    logic [VALUE_W-1:0] val;
    logic [VALUE_W-1:0] acc;
    logic [VALUE_W-1:0] supp;

    assign acc  = {r_val[VALUE_W-7:0], i_byte[5:0]};
    assign supp = val - C_SUPP_BASE;

    always_comb begin
        n_pend = r_pend;
        n_val  = r_val;
        emit   = 1'b0;
        val    = {{(VALUE_W-7){1'b0}}, i_byte[6:0]};
        if (r_pend != '0 && i_byte[7:6] == 2'b10) begin
            n_val  = acc;
            n_pend = r_pend - 3'd1;
            if (r_pend == 3'd1) begin
                emit  = 1'b1;
                val   = acc;
                n_val = '0;
            end
        end else begin
            // open sequence (if any) is dropped, byte handled afresh
            n_pend = '0;
            n_val  = '0;
            case (i_byte) inside
                [8'h00:8'h7F]: begin
                    emit = 1'b1;
                end
                [8'hC0:8'hDF]: begin
                    n_pend = 3'd1;
                    n_val  = {{(VALUE_W-5){1'b0}}, i_byte[4:0]};
                end
                [8'hE0:8'hEF]: begin
                    n_pend = 3'd2;
                    n_val  = {{(VALUE_W-4){1'b0}}, i_byte[3:0]};
                end
                [8'hF0:8'hF7]: begin
                    n_pend = 3'd3;
                    n_val  = {{(VALUE_W-3){1'b0}}, i_byte[2:0]};
                end
                [8'hF8:8'hFB]: begin
                    n_pend = 3'd4;
                    n_val  = {{(VALUE_W-2){1'b0}}, i_byte[1:0]};
                end
                [8'hFC:8'hFD]: begin
                    n_pend = 3'd5;
                    n_val  = {{(VALUE_W-1){1'b0}}, i_byte[0]};
                end
                default: begin
                    // stray continuation, 0xFE, 0xFF: skipped
                end
            endcase
        end
        if (i_last) begin
            n_pend = '0;
            n_val  = '0;
        end
    end

    always_comb begin
        o_res               = '0;
        o_res.u0.stream_end = i_last;
        o_res.u1.stream_end = i_last;
        o_res.u1.run_last   = 1'b1;
        if (emit) begin
            if (val[VALUE_W-1:UNIT_W] == '0) begin
                o_res.cnt          = 2'd1;
                o_res.u0.code_unit = val[UNIT_W-1:0];
                o_res.u0.run_last  = 1'b1;
            end else begin
                // surrogate pair; high half wraps past 0x10FFFF
                o_res.cnt          = 2'd2;
                o_res.u0.code_unit = supp[25:10] + C_HI_SURR;
                o_res.u0.run_last  = 1'b0;
                o_res.u1.code_unit = {6'b0, supp[9:0]} + C_LO_SURR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_val  <= '0;
        end else if (i_valid) begin
            r_pend <= n_pend;
            r_val  <= n_val;
        end
    end

endmodule
`default_nettype wire

[design/utf8_to_utf16_transcoder_top.sv]
// A byte is registered in the input stage, decoded combinationally and its units written
// to a three-entry unit queue whose head drives the single-unit output port.
// Throughput: one byte per cycle while the queue has room for a pair; a byte giving a
// surrogate pair holds the output port for both units, so a run of them stalls the input.
// Reset (synchronous, active low) closes any open sequence and empties both stages.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_to_utf16_transcoder_top_macros.svh"
module utf8_to_utf16_transcoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  wire logic        s_axis_tlast,   // stream_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] code_unit
    output logic             m_axis_tlast,   // run_last
    output logic             m_axis_tuser    // [0] stream_end
);
    import u8u16_pkg::*;

    localparam int unsigned QDEPTH = 3;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;

    logic              adv;
    logic              pop;
    t_dec_res          res;

    t_unit             r_q [QDEPTH];
    t_unit             n_q [QDEPTH];
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    logic [1:0]        cnt_after;
    logic [1:0]        push_cnt;

    // decode stage advances only when the queue has room for a pair
    assign adv           = r_in_valid && (r_cnt <= 2'd1);
    assign s_axis_tready = !r_in_valid || adv;
    assign pop           = m_axis_tvalid && m_axis_tready;

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_q[0].code_unit;
    assign m_axis_tlast  = r_q[0].run_last;
    assign m_axis_tuser  = r_q[0].stream_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_byte <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
    end

    u8u16_decode u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (adv),
        .i_byte  (r_byte),
        .i_last  (r_last),
        .o_res   (res)
    );

    assign push_cnt  = adv ? res.cnt : 2'd0;
    assign cnt_after = r_cnt - {1'b0, pop};
    assign n_cnt     = cnt_after + push_cnt;

    always_comb begin
        for (int i = 0; i < QDEPTH; i++) begin
            if (pop && i < QDEPTH - 1) begin
                n_q[i] = r_q[i+1];
            end else begin
                n_q[i] = r_q[i];
            end
            if (push_cnt != 2'd0 && cnt_after == 2'(i)) begin
                n_q[i] = res.u0;
            end
            if (push_cnt == 2'd2 && cnt_after + 2'd1 == 2'(i)) begin
                n_q[i] = res.u1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    `U8U16_ASSERT_ALWAYS(a_cnt_range, r_cnt <= 2'd3, "unit queue count out of range")
    `U8U16_ASSERT_IMPL(a_pair_whole, (r_cnt != 2'd0) && !r_q[0].run_last, r_cnt >= 2'd2,
        "high surrogate at head without its low half queued")
    `U8U16_ASSERT_NEXT(a_stall_keeps, m_axis_tvalid && !m_axis_tready,
        r_cnt >= $past(r_cnt), "queue lost units while output stalled")

endmodule
`default_nettype wire
